// ===== sv/watchdog_clock_step_random_slot_defines.svh =====
// Assertion helpers for the watchdog clock stepper.
`ifndef WATCHDOG_CLOCK_STEP_RANDOM_SLOT_DEFINES_SVH
`define WATCHDOG_CLOCK_STEP_RANDOM_SLOT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define WDCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies another on the same edge.
`define WDCS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies another on the next edge.
`define WDCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/wdcs_pkg.sv =====
package wdcs_pkg;

  localparam int NOW_W    = 62;
  localparam int PICK_W   = 4;
  localparam int ERR_W    = 63;
  localparam int CFG_W    = 30;
  localparam int CFG_IDX_W = 2;
  localparam int NSEC_W   = 30;
  localparam int POW_W    = 60;

  localparam int SLOT_CHOICES = 11;

  localparam logic [CFG_IDX_W-1:0] REG_SLOT_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ERR_THRESH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP    = 2'd2;

  localparam logic [CFG_W-1:0] SLOT_LENGTH_RST = 30'd100000000;
  localparam logic [CFG_W-1:0] ERR_THRESH_RST  = 30'd483302;
  localparam logic [CFG_W-1:0] MAX_STEP_RST    = 30'd10000000;

  localparam logic [NSEC_W-1:0] NS_PER_SEC     = 30'd1000000000;
  localparam logic [NSEC_W-1:0] STEP_LIMIT_MAX = 30'd999999999;

  // Highest power of ten compared during digit counting.
  localparam logic [4:0] MAX_EXP = 5'd18;

  function automatic logic [POW_W-1:0] pow10(input logic [4:0] k);
    logic [POW_W-1:0] v;
    case (k)
      5'd0:  v = 60'd1;
      5'd1:  v = 60'd10;
      5'd2:  v = 60'd100;
      5'd3:  v = 60'd1000;
      5'd4:  v = 60'd10000;
      5'd5:  v = 60'd100000;
      5'd6:  v = 60'd1000000;
      5'd7:  v = 60'd10000000;
      5'd8:  v = 60'd100000000;
      5'd9:  v = 60'd1000000000;
      5'd10: v = 60'd10000000000;
      5'd11: v = 60'd100000000000;
      5'd12: v = 60'd1000000000000;
      5'd13: v = 60'd10000000000000;
      5'd14: v = 60'd100000000000000;
      5'd15: v = 60'd1000000000000000;
      5'd16: v = 60'd10000000000000000;
      5'd17: v = 60'd100000000000000000;
      5'd18: v = 60'd1000000000000000000;
      default: v = 60'd1;
    endcase
    return v;
  endfunction

  // Reduce a slot pick into 0..SLOT_CHOICES-1.
  function automatic logic [PICK_W-1:0] pick_mod(input logic [PICK_W-1:0] p);
    logic [PICK_W:0] m;
    m = {1'b0, p};
    for (int i = 0; i < 8; i++) begin
      if (m >= (PICK_W+1)'(SLOT_CHOICES)) m = m - (PICK_W+1)'(SLOT_CHOICES);
    end
    return m[PICK_W-1:0];
  endfunction

endpackage

// ===== sv/wdcs_in_if.sv =====
interface wdcs_in_if;
  import wdcs_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [NOW_W-1:0]         now_ns;
  logic [PICK_W-1:0]        first_pick;
  logic [PICK_W-1:0]        next_pick;
  logic signed [ERR_W-1:0]  error_ns;
  logic signed [ERR_W-1:0]  master_offset_ns;

  modport source (
    output valid, now_ns, first_pick, next_pick, error_ns, master_offset_ns,
    input  ready
  );
  modport sink (
    input  valid, now_ns, first_pick, next_pick, error_ns, master_offset_ns,
    output ready
  );
endinterface

// ===== sv/wdcs_out_if.sv =====
interface wdcs_out_if;
  import wdcs_pkg::*;

  logic              valid;
  logic              ready;
  logic              inspected;
  logic              apply_step;
  logic signed [0:0] step_sec;
  logic [NSEC_W-1:0] step_nsec;

  modport source (
    output valid, inspected, apply_step, step_sec, step_nsec,
    input  ready
  );
  modport sink (
    input  valid, inspected, apply_step, step_sec, step_nsec,
    output ready
  );
endinterface

// ===== sv/wdcs_cfg_if.sv =====
interface wdcs_cfg_if;
  import wdcs_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

// ===== sv/watchdog_clock_step_random_slot.sv =====
// Path: a tick before its inspection time goes from S_DUE straight to S_FIN; an
// inspection inside the deadband passes S_PREP first; a step also runs S_MAG, 18 + 18
// digit compares, 63 restoring-division steps (all on one shared 63-bit subtractor), S_CLAMP.
// The next item is accepted the cycle after the result is loaded into the output
// register; no new item is taken before that, and S_FIN holds while out is not free.
// Reset (rst_n low, synchronous): disarmed, schedule zero, registers at defaults.
module watchdog_clock_step_random_slot (
  input  logic        clk,
  input  logic        rst_n,
  wdcs_in_if.sink     in_ch,
  wdcs_out_if.source  out_ch,
  wdcs_cfg_if.sink    cfg_ch
);
  import wdcs_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DUE   = 9'b000000010,
    S_PREP  = 9'b000000100,
    S_MAG   = 9'b000001000,
    S_DIG_E = 9'b000010000,
    S_DIG_M = 9'b000100000,
    S_DIV   = 9'b001000000,
    S_CLAMP = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0] slot_r, slot_nxt;
  logic [CFG_W-1:0] thr_r, thr_nxt;
  logic [CFG_W-1:0] maxstep_r, maxstep_nxt;

  logic              armed_r, armed_nxt;
  logic [ERR_W-1:0]  next_r, next_nxt;

  logic [NOW_W-1:0]  now_r, now_nxt;
  logic [PICK_W-1:0] pick_r, pick_nxt;
  logic [ERR_W-1:0]  err_r, err_nxt;
  logic [ERR_W-1:0]  master_r, master_nxt;

  logic [ERR_W:0]    e_r, e_nxt;
  logic              neg_r, neg_nxt;
  logic [ERR_W-1:0]  mag_r, mag_nxt;
  logic [ERR_W-1:0]  am_r, am_nxt;
  logic [POW_W-1:0]  rem_r, rem_nxt;
  logic [5:0]        cnt_r, cnt_nxt;
  logic signed [5:0] diff_r, diff_nxt;
  logic [4:0]        didx_r, didx_nxt;
  logic [NSEC_W-1:0] m_r, m_nxt;
  logic              insp_r, insp_nxt;
  logic              apply_r, apply_nxt;

  logic              ov_r, ov_nxt;
  logic              oinsp_r, oinsp_nxt;
  logic              oapply_r, oapply_nxt;
  logic              osec_r, osec_nxt;
  logic [NSEC_W-1:0] onsec_r, onsec_nxt;

  // Shared subtract/compare unit.
  logic [ERR_W-1:0]  ua, ub;
  logic [ERR_W:0]    udiff;
  logic              uge;

  logic              in_acc, out_acc, out_free;
  logic [PICK_W-1:0] pick_sel;
  logic [NOW_W-1:0]  now_sel;
  logic [33:0]       delay_w;
  logic [ERR_W-1:0]  sched_w;
  logic [ERR_W:0]    e_w, f_w;
  logic              band_out_w;
  logic [POW_W:0]    cand_w;
  logic signed [5:0] diff_fin_w;
  logic [NSEC_W-1:0] lim_w;
  logic              sec_w;

  assign udiff = {1'b0, ua} - {1'b0, ub};
  assign uge   = ~udiff[ERR_W];

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_acc      = ov_r && out_ch.ready;
  assign out_free     = !ov_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid      = ov_r;
  assign out_ch.inspected  = oinsp_r;
  assign out_ch.apply_step = oapply_r;
  assign out_ch.step_sec   = osec_r;
  assign out_ch.step_nsec  = onsec_r;

  assign pick_sel = (state_r == S_IDLE) ? in_ch.first_pick : pick_r;
  assign now_sel  = (state_r == S_IDLE) ? in_ch.now_ns : now_r;
  assign delay_w  = 34'(pick_mod(pick_sel)) * 34'(slot_r);
  assign sched_w  = {1'b0, now_sel} + ERR_W'(delay_w);

  assign e_w        = {err_r[ERR_W-1], err_r} - (ERR_W+1)'(thr_r);
  assign f_w        = {err_r[ERR_W-1], err_r} + (ERR_W+1)'(thr_r);
  assign band_out_w = (!e_w[ERR_W] && (e_w != '0)) || f_w[ERR_W];

  assign cand_w     = {rem_r, mag_r[ERR_W-1]};
  assign diff_fin_w = diff_r - 6'(uge);
  assign lim_w      = (maxstep_r > STEP_LIMIT_MAX) ? STEP_LIMIT_MAX : maxstep_r;
  assign sec_w      = apply_r && neg_r && (m_r != '0);

  always_comb begin
    ua = mag_r;
    ub = ERR_W'(pow10(cnt_r[4:0]));
    unique case (state_r)
      S_DUE: begin
        ua = {1'b0, now_r};
        ub = next_r;
      end
      S_DIG_M: ua = am_r;
      S_DIV: begin
        ua = ERR_W'(cand_w);
        ub = ERR_W'(pow10(didx_r));
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    slot_nxt    = slot_r;
    thr_nxt     = thr_r;
    maxstep_nxt = maxstep_r;
    armed_nxt   = armed_r;
    next_nxt    = next_r;
    now_nxt     = now_r;
    pick_nxt    = pick_r;
    err_nxt     = err_r;
    master_nxt  = master_r;
    e_nxt       = e_r;
    neg_nxt     = neg_r;
    mag_nxt     = mag_r;
    am_nxt      = am_r;
    rem_nxt     = rem_r;
    cnt_nxt     = cnt_r;
    diff_nxt    = diff_r;
    didx_nxt    = didx_r;
    m_nxt       = m_r;
    insp_nxt    = insp_r;
    apply_nxt   = apply_r;
    ov_nxt      = ov_r;
    oinsp_nxt   = oinsp_r;
    oapply_nxt  = oapply_r;
    osec_nxt    = osec_r;
    onsec_nxt   = onsec_r;

    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_SLOT_LENGTH: slot_nxt    = cfg_ch.data;
        REG_ERR_THRESH:  thr_nxt     = cfg_ch.data;
        REG_MAX_STEP:    maxstep_nxt = cfg_ch.data;
        default: ;
      endcase
    end

    if (out_acc) ov_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          now_nxt    = in_ch.now_ns;
          pick_nxt   = in_ch.next_pick;
          err_nxt    = in_ch.error_ns;
          master_nxt = in_ch.master_offset_ns;
          if (!armed_r) begin
            armed_nxt = 1'b1;
            next_nxt  = sched_w;
          end
          state_nxt = S_DUE;
        end
      end
      S_DUE: begin
        neg_nxt   = 1'b0;
        m_nxt     = '0;
        apply_nxt = 1'b0;
        insp_nxt  = uge;
        state_nxt = uge ? S_PREP : S_FIN;
      end
      S_PREP: begin
        e_nxt     = e_w;
        state_nxt = band_out_w ? S_MAG : S_FIN;
      end
      S_MAG: begin
        neg_nxt   = e_r[ERR_W];
        mag_nxt   = e_r[ERR_W] ? ERR_W'(-e_r) : e_r[ERR_W-1:0];
        am_nxt    = master_r[ERR_W-1] ? (~master_r + ERR_W'(1)) : master_r;
        cnt_nxt   = 6'd1;
        diff_nxt  = '0;
        state_nxt = S_DIG_E;
      end
      S_DIG_E: begin
        if (uge) diff_nxt = diff_r + 6'sd1;
        if (cnt_r[4:0] == MAX_EXP) begin
          cnt_nxt   = 6'd1;
          state_nxt = S_DIG_M;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      S_DIG_M: begin
        if (cnt_r[4:0] == MAX_EXP) begin
          // Divisor is ten to the excess digit count, or one when there is none.
          didx_nxt  = (diff_fin_w > 6'sd0) ? diff_fin_w[4:0] : 5'd0;
          cnt_nxt   = '0;
          rem_nxt   = '0;
          state_nxt = S_DIV;
        end else begin
          diff_nxt = diff_fin_w;
          cnt_nxt  = cnt_r + 6'd1;
        end
      end
      S_DIV: begin
        rem_nxt = uge ? udiff[POW_W-1:0] : cand_w[POW_W-1:0];
        mag_nxt = {mag_r[ERR_W-2:0], uge};
        if (cnt_r == 6'(ERR_W - 1)) begin
          state_nxt = S_CLAMP;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      S_CLAMP: begin
        m_nxt     = (mag_r > ERR_W'(lim_w)) ? lim_w : mag_r[NSEC_W-1:0];
        apply_nxt = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // Hold until the output register is free, then load it and, after an inspection, reschedule.
        if (out_free) begin
          ov_nxt     = 1'b1;
          oinsp_nxt  = insp_r;
          oapply_nxt = apply_r;
          osec_nxt   = sec_w;
          onsec_nxt  = sec_w ? (NS_PER_SEC - m_r) : m_r;
          if (insp_r) next_nxt = sched_w;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      slot_r    <= SLOT_LENGTH_RST;
      thr_r     <= ERR_THRESH_RST;
      maxstep_r <= MAX_STEP_RST;
      armed_r   <= 1'b0;
      next_r    <= '0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      slot_r    <= slot_nxt;
      thr_r     <= thr_nxt;
      maxstep_r <= maxstep_nxt;
      armed_r   <= armed_nxt;
      next_r    <= next_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r    <= now_nxt;
    pick_r   <= pick_nxt;
    err_r    <= err_nxt;
    master_r <= master_nxt;
    e_r      <= e_nxt;
    neg_r    <= neg_nxt;
    mag_r    <= mag_nxt;
    am_r     <= am_nxt;
    rem_r    <= rem_nxt;
    cnt_r    <= cnt_nxt;
    diff_r   <= diff_nxt;
    didx_r   <= didx_nxt;
    m_r      <= m_nxt;
    insp_r   <= insp_nxt;
    apply_r  <= apply_nxt;
    oinsp_r  <= oinsp_nxt;
    oapply_r <= oapply_nxt;
    osec_r   <= osec_nxt;
    onsec_r  <= onsec_nxt;
  end

`include "watchdog_clock_step_random_slot_defines.svh"

  `WDCS_ASSERT_NEXT(a_armed_after_item, in_acc, armed_r, "not armed after an item")
  `WDCS_ASSERT_IMPL(a_div_rem_bound, state_r == S_DIV, rem_r < pow10(didx_r), "remainder not below divisor")
  `WDCS_ASSERT_IMPL(a_idle_result_zero, ov_r && !oinsp_r, !oapply_r && !osec_r && (onsec_r == '0), "idle tick carries a step")
  `WDCS_ASSERT_IMPL(a_step_within_limit, ov_r && oapply_r && !osec_r, onsec_r <= lim_w, "positive step above limit")

endmodule

// ===== dv/testbench.sv =====
module testbench;
  import wdcs_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int TIMEOUT_CYCLES = 1000000;
  localparam int ITEMS_PER_PHASE = 75;
  localparam int DRAIN_CYCLES = 120;
  localparam longint ERR_MAX = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam longint ERR_MIN = -ERR_MAX - 1;
  localparam longint unsigned NOW_MAX = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam longint unsigned TOP_BASE = NOW_MAX - 64'h0000_1000_0000_0000;
  localparam logic [CFG_W-1:0] CFG_ONES = '1;

  typedef struct {
    logic [NOW_W-1:0]        now_ns;
    logic [PICK_W-1:0]       first_pick;
    logic [PICK_W-1:0]       next_pick;
    logic signed [ERR_W-1:0] error_ns;
    logic signed [ERR_W-1:0] master_offset_ns;
  } tick_t;

  typedef struct packed {
    logic              inspected;
    logic              apply_step;
    logic              step_sec;
    logic [NSEC_W-1:0] step_nsec;
  } step_result_t;

  class step_checker;
    logic [CFG_W-1:0] slot_len;
    logic [CFG_W-1:0] thr;
    logic [CFG_W-1:0] max_step;
    bit               armed;
    longint unsigned  next_due;
    step_result_t     due[$];
    int               mismatches;

    function new();
      slot_len   = SLOT_LENGTH_RST;
      thr        = ERR_THRESH_RST;
      max_step   = MAX_STEP_RST;
      armed      = 1'b0;
      next_due   = 0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_SLOT_LENGTH: slot_len = val;
        REG_ERR_THRESH:  thr = val;
        REG_MAX_STEP:    max_step = val;
        default: ;
      endcase
    endfunction

    function longint unsigned slot_delay(logic [PICK_W-1:0] pick);
      return longint'(pick % SLOT_CHOICES) * longint'(slot_len);
    endfunction

    function int digits(longint unsigned x);
      int n;
      n = 1;
      while (x >= 10) begin
        x = x / 10;
        n++;
      end
      return n;
    endfunction

    function longint unsigned magnitude(longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    function void note_tick(tick_t t);
      longint unsigned cur;
      longint err, mo, lvl, e, scaled, cap;
      int shift;
      step_result_t r;
      cur = t.now_ns;
      err = t.error_ns;
      mo  = t.master_offset_ns;
      lvl = longint'(thr);
      r   = '0;
      if (!armed) begin
        armed = 1'b1;
        next_due = cur + slot_delay(t.first_pick);
      end
      if (cur < next_due) begin
        due.push_back(r);
        return;
      end
      r.inspected = 1'b1;
      if (err > lvl || err < -lvl) begin
        e = err - lvl;
        // scale down to the digit count of the master offset
        shift = digits(magnitude(e)) - digits(magnitude(mo));
        scaled = e;
        while (shift > 0) begin
          scaled = scaled / 10;
          shift--;
        end
        cap = (max_step > STEP_LIMIT_MAX) ? longint'(STEP_LIMIT_MAX) : longint'(max_step);
        if (scaled > cap) scaled = cap;
        else if (scaled < -cap) scaled = -cap;
        r.apply_step = 1'b1;
        if (scaled < 0) begin
          r.step_sec  = 1'b1;
          r.step_nsec = NSEC_W'(scaled + longint'(NS_PER_SEC));
        end else begin
          r.step_nsec = NSEC_W'(scaled);
        end
      end
      next_due = cur + slot_delay(t.next_pick);
      due.push_back(r);
    endfunction

    function void report(string why, step_result_t want, step_result_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%s: expected insp=%0b step=%0b sec=%0b nsec=%0d, got insp=%0b step=%0b sec=%0b nsec=%0d",
                 why, want.inspected, want.apply_step, want.step_sec, want.step_nsec,
                 got.inspected, got.apply_step, got.step_sec, got.step_nsec);
    endfunction

    function void check_result(step_result_t got);
      step_result_t want;
      if (due.size() == 0) begin
        report("result with no tick pending", '0, got);
        return;
      end
      want = due.pop_front();
      if (got.inspected !== want.inspected || got.apply_step !== want.apply_step ||
          got.step_sec !== want.step_sec || got.step_nsec !== want.step_nsec)
        report("step mismatch", want, got);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int send_idle_pct;
  int recv_stall_pct;
  longint unsigned time_base;
  step_checker sb = new();

  wdcs_in_if  in_ch();
  wdcs_out_if out_ch();
  wdcs_cfg_if cfg_ch();

  watchdog_clock_step_random_slot i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #(CLK_PERIOD/2) clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result({out_ch.inspected, out_ch.apply_step, out_ch.step_sec, out_ch.step_nsec});
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic longint unsigned rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic longint unsigned rand_digits(int d);
    longint unsigned p;
    p = 1;
    repeat (d) p = p * 10;
    return rand64() % p;
  endfunction

  function automatic longint signed_digits(int d);
    longint unsigned m;
    m = rand_digits(d) & NOW_MAX;
    return $urandom_range(1) ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic signed [ERR_W-1:0] rand_error(logic [CFG_W-1:0] dead);
    longint lvl, v;
    lvl = longint'(dead);
    case ($urandom_range(9))
      0: v = 0;
      1: v = lvl;
      2: v = -lvl;
      3: v = lvl + 1;
      4: v = -lvl - 1;
      5: v = longint'(rand64() % longint'(2 * lvl + 1)) - lvl;
      6, 7: v = signed_digits($urandom_range(1, 19));
      8: v = longint'(rand64());
      default: v = $urandom_range(1) ? ERR_MAX : ERR_MIN;
    endcase
    return ERR_W'(v);
  endfunction

  function automatic logic signed [ERR_W-1:0] rand_master();
    longint v;
    case ($urandom_range(7))
      0: v = 0;
      1: v = $urandom_range(1) ? ERR_MAX : ERR_MIN;
      2: v = longint'(rand64());
      default: v = signed_digits($urandom_range(1, 19));
    endcase
    return ERR_W'(v);
  endfunction

  function automatic logic [CFG_W-1:0] rand_reg();
    return CFG_W'(rand_digits($urandom_range(1, 9)));
  endfunction

  // Mostly advance time by whole slots plus part of a slot, often land within one ns
  // of the due time, and now and then step back to an earlier time.
  function automatic tick_t random_tick();
    tick_t t;
    int roll;
    longint unsigned cur, slot;
    roll = $urandom_range(99);
    slot = sb.slot_len;
    if (roll < 4 && time_base > 0) begin
      cur = rand64() % time_base;
    end else if (roll < 30 && sb.armed && sb.next_due != 0) begin
      cur = sb.next_due - 1 + $urandom_range(2);
      if (cur > time_base) time_base = cur;
    end else begin
      time_base += $urandom_range(11) * slot + ((slot == 0) ? $urandom_range(3) : rand64() % slot);
      cur = time_base;
    end
    t.now_ns           = NOW_W'(cur);
    t.first_pick       = PICK_W'($urandom_range(15));
    t.next_pick        = PICK_W'($urandom_range(15));
    t.error_ns         = rand_error(sb.thr);
    t.master_offset_ns = rand_master();
    return t;
  endfunction

  task automatic send_tick(tick_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.now_ns           <= t.now_ns;
    in_ch.first_pick       <= t.first_pick;
    in_ch.next_pick        <= t.next_pick;
    in_ch.error_ns         <= t.error_ns;
    in_ch.master_offset_ns <= t.master_offset_ns;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_tick(t);
  endtask

  task automatic drive_tick(longint unsigned cur, int fp, int np, longint err, longint mo);
    tick_t t;
    t.now_ns           = NOW_W'(cur);
    t.first_pick       = PICK_W'(fp);
    t.next_pick        = PICK_W'(np);
    t.error_ns         = ERR_W'(err);
    t.master_offset_ns = ERR_W'(mo);
    send_tick(t);
  endtask

  // Drop valid and hold until every pending result has come back.
  task automatic finish_batch();
    in_ch.valid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_reg(idx, val);
  endtask

  task automatic load_config(logic [CFG_W-1:0] slot, logic [CFG_W-1:0] dead,
                             logic [CFG_W-1:0] cap);
    cfg_write(REG_SLOT_LENGTH, slot);
    cfg_write(REG_ERR_THRESH, dead);
    cfg_write(REG_MAX_STEP, cap);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("watchdog_clock_step_random_slot verification failed");
    $finish;
  end

  initial begin
    rst_n                  = 1'b0;
    in_ch.valid            = 1'b0;
    in_ch.now_ns           = '0;
    in_ch.first_pick       = '0;
    in_ch.next_pick        = '0;
    in_ch.error_ns         = '0;
    in_ch.master_offset_ns = '0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.index           = REG_SLOT_LENGTH;
    cfg_ch.data            = '0;
    send_idle_pct          = 0;
    recv_stall_pct         = 0;
    time_base              = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: arm and inspect on the first tick, deadband edges,
    // out-of-range picks, zero master offset, clamping both ways
    drive_tick(0, 0, 3, 0, 7);
    drive_tick(299999999, 9, 5, 12345678, 1);
    drive_tick(300000000, 15, 15, 483303, 1);
    drive_tick(700000000, 11, 11, -483303, 0);
    drive_tick(700000000, 12, 0, 483302, 42);
    drive_tick(700000000, 13, 0, -483302, -42);
    drive_tick(700000000, 14, 10, ERR_MAX, ERR_MIN);
    drive_tick(1700000000, 1, 12, ERR_MIN, ERR_MAX);
    drive_tick(1800000000, 2, 13, 64'sd12345678901, 5);
    drive_tick(2000000000, 4, 14, -64'sd1000000000000000, 0);
    drive_tick(64'd2299999999, 8, 1, -64'sd98765432109, -333);
    drive_tick(5, 6, 2, 0, 0);
    finish_batch();

    // zero slot length and zero step limit, then an oversize limit
    load_config(0, 0, 0);
    drive_tick(64'd2300000000, 3, 7, 5, 3);
    drive_tick(64'd2300000000, 10, 9, -5, 3);
    drive_tick(64'd2300000000, 7, 4, 0, 0);
    finish_batch();
    load_config(0, 0, CFG_ONES);
    drive_tick(64'd2300000001, 5, 6, ERR_MIN, 1);
    drive_tick(64'd2300000002, 0, 8, ERR_MAX, -1);
    finish_batch();
    time_base = 64'd2300000002;

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: load_config(SLOT_LENGTH_RST, ERR_THRESH_RST, MAX_STEP_RST);
        1: load_config(1, 0, 1);
        2: load_config(1000000000, 1000000000, 999999999);
        4: load_config(CFG_ONES, CFG_ONES, CFG_ONES);
        6: load_config(37, 5, 0);
        default: load_config(rand_reg(), rand_reg(), rand_reg());
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      // skip past any inspection scheduled under the old slot length;
      // the last phase runs near the top of the time range
      if (ph == 7) time_base = TOP_BASE;
      else if (sb.next_due > time_base) time_base = sb.next_due;
      repeat (ITEMS_PER_PHASE) send_tick(random_tick());
      if (ph == 7) drive_tick(NOW_MAX, 15, 10, ERR_MAX, 9);
      finish_batch();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.due.size() == 0)
      $display("watchdog_clock_step_random_slot verification clean");
    else
      $display("watchdog_clock_step_random_slot verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/wdcs_pkg.sv
sv/wdcs_in_if.sv
sv/wdcs_out_if.sv
sv/wdcs_cfg_if.sv
sv/watchdog_clock_step_random_slot.sv
dv/testbench.sv
